// ----- rtl/plist_pkg.sv -----
// ---------------------------------------------------------------------------
// Positional list package
// Shared sizes, command and status codes, and the cell control word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plist_pkg;

  localparam int CAPACITY      = 64;
  localparam int ELEMENT_WIDTH = 32;

  // index of one cell, and a count that can hold CAPACITY itself
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // common width for comparing the 8-bit position against the count
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  // element width wide enough for both the 32-bit field and the store
  localparam int ELEM_XW = (ELEMENT_WIDTH > 32) ? ELEMENT_WIDTH : 32;

  // stream word layout
  localparam int IN_CMD_LSB   = 0;
  localparam int IN_POS_LSB   = 2;
  localparam int IN_ELEM_LSB  = 10;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_ST_LSB   = 0;
  localparam int OUT_ELEM_LSB = 2;
  localparam int OUT_CNT_LSB  = 34;
  localparam int OUT_EMP_BIT  = 41;
  localparam int OUT_TDATA_W  = 48;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_REM  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         at;
    logic [IDX_W-1:0]         rd_idx;
    logic [ELEMENT_WIDTH-1:0] elem;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/positional_list_insert_remove_unit.sv -----
// ---------------------------------------------------------------------------
// Positional list insert/remove unit
// Bounded ordered list of element handles kept in a row of shifting cells.
// ---------------------------------------------------------------------------
// Output: the result word of an accepted request is registered and offered in the next cycle.
// Throughput: one request per cycle while the result side takes every word;
//   the whole row of cells shifts at once, and the one output
//   register is the only thing that can hold the input back.
// Reset: rst clears the entry count and the output valid; cell contents are
//   left as they are, since no entry is read before it has been written.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_insert_remove_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // request stream; tdata: cmd[1:0], position[9:2], element[41:10], zero pad
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [plist_pkg::IN_TDATA_W-1:0]    s_tdata,
  // result stream; tdata: status[1:0], element_out[33:2], count[40:34],
  // is_empty[41], zero pad
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [plist_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import plist_pkg::*;

  // request fields
  logic [1:0]               cmd;
  logic [7:0]               position;
  logic [31:0]              element;
  logic [ELEMENT_WIDTH-1:0] elem_in;

  logic                     accept;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [CMP_W-1:0]         pos_w;
  logic [CMP_W-1:0]         cnt_w;
  logic [CMP_W-1:0]         last_w;
  logic                     is_full;
  logic                     is_none;
  logic [IDX_W-1:0]         ins_at;
  logic [IDX_W-1:0]         rem_at;

  cell_op_t                 op;
  logic [1:0]               status;
  logic                     use_tap;
  cell_ctrl_t               ctrl;

  logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] cell_tap  [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] rd_data;
  logic [ELEM_XW-1:0]       rd_ext;

  // output word register
  logic [1:0]               status_r;
  logic [31:0]              elem_out_r;
  logic [6:0]               count_r;
  logic                     empty_r;

  assign cmd      = s_tdata[IN_CMD_LSB +: 2];
  assign position = s_tdata[IN_POS_LSB +: 8];
  assign element  = s_tdata[IN_ELEM_LSB +: 32];
  // store only ELEMENT_WIDTH bits of the handle
  assign elem_in  = ELEMENT_WIDTH'(ELEM_XW'(element));

  // one word in flight: take a new request whenever the output slot frees
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign pos_w   = CMP_W'(position);
  assign cnt_w   = CMP_W'(count);
  assign last_w  = cnt_w - CMP_W'(1);
  assign is_full = (count == CNT_W'(CAPACITY));
  assign is_none = (count == '0);

  // positions past the end clamp to the end (append / take the last entry)
  assign ins_at = (pos_w >= cnt_w)  ? IDX_W'(count)  : pos_w[IDX_W-1:0];
  assign rem_at = (pos_w >= last_w) ? last_w[IDX_W-1:0] : pos_w[IDX_W-1:0];

  // decode the request into a cell operation, a status and the new count
  always_comb begin
    op         = OP_HOLD;
    status     = ST_OK;
    use_tap    = 1'b0;
    count_next = count;
    case (cmd)
      CMD_INSERT: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          op         = OP_INS;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (is_none) begin
          status = ST_EMPTY;
        end else begin
          op         = OP_REM;
          use_tap    = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (is_none) begin
          status = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          use_tap = 1'b1;
        end
      end
      default: ;  // unused code: report ok, change nothing
    endcase
  end

  always_comb begin
    ctrl.op     = accept ? op : OP_HOLD;
    ctrl.at     = (cmd == CMD_REMOVE) ? rem_at : ins_at;
    ctrl.rd_idx = (cmd == CMD_REMOVE) ? rem_at : pos_w[IDX_W-1:0];
    ctrl.elem   = elem_in;
  end

  // row of cells; each end sees zeros past the edge
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] left_d;
    logic [ELEMENT_WIDTH-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_inner_l
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner_r
      assign right_d = cell_data[g+1];
    end
    plist_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (IDX_W'(g)),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .tap        (cell_tap[g])
    );
  end

  // at most one tap is non-zero, so OR them together
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | cell_tap[i];
    end
  end
  assign rd_ext = ELEM_XW'(rd_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload: load with each accepted request, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= status;
      elem_out_r <= use_tap ? rd_ext[31:0] : 32'd0;
      count_r    <= 7'(count_next);
      empty_r    <= (count_next == '0);
    end
  end

  always_comb begin
    m_tdata                      = '0;
    m_tdata[OUT_ST_LSB +: 2]     = status_r;
    m_tdata[OUT_ELEM_LSB +: 32]  = elem_out_r;
    m_tdata[OUT_CNT_LSB +: 7]    = count_r;
    m_tdata[OUT_EMP_BIT]         = empty_r;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_INSERT && !is_full |=> count == $past(count) + CNT_W'(1))
    else $error("accepted insert did not grow the list");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_INSERT && is_full |=> count == $past(count) && status_r == ST_FULL)
    else $error("insert into a full list changed the count");

  // a waiting result word always reports the list as it now stands
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> count_r == 7'(count) && empty_r == (count == '0))
    else $error("result word count or empty flag disagrees with the list");
`endif

endmodule

`default_nettype wire

// ----- rtl/plist_cell.sv -----
// ---------------------------------------------------------------------------
// Positional list cell
// Holds one entry; takes the left neighbour on insert, the right one on
// remove, and offers its entry on the read tap when addressed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plist_cell (
  input  wire logic                                  clk,
  input  wire plist_pkg::cell_ctrl_t                 ctrl,
  input  wire logic [plist_pkg::IDX_W-1:0]           idx,
  input  wire logic [plist_pkg::ELEMENT_WIDTH-1:0]   left_data,
  input  wire logic [plist_pkg::ELEMENT_WIDTH-1:0]   right_data,
  output logic      [plist_pkg::ELEMENT_WIDTH-1:0]   data,
  output logic      [plist_pkg::ELEMENT_WIDTH-1:0]   tap
);
  import plist_pkg::*;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INS: begin
        if (idx == ctrl.at) begin
          data <= ctrl.elem;
        end else if (idx > ctrl.at) begin
          data <= left_data;
        end
      end
      OP_REM: begin
        if (idx >= ctrl.at) begin
          data <= right_data;
        end
      end
      default: ;
    endcase
  end

  assign tap = (idx == ctrl.rd_idx) ? data : '0;

endmodule

`default_nettype wire

// ----- test/positional_list_insert_remove_unit_tb.sv -----
// ---------------------------------------------------------------------------
// Positional list insert/remove unit testbench
// Drives insert, remove and read requests with random gaps on both streams,
// keeps a shadow copy of the list, and checks every result word field by
// field against the outcome that the shadow list predicts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_insert_remove_unit_tb;
  import plist_pkg::*;

  // code three is reserved: the unit must leave the list alone
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [31:0] ELEM_MASK =
    (ELEMENT_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << ELEMENT_WIDTH) - 32'd1);
  // cycles with no word moving on either side before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  // window with no idling on either side
  localparam int CALM_FROM = 400;
  localparam int CALM_TO   = 900;
  localparam int IDLE_PCT  = 14;
  localparam int RANDOM_WORDS = 1200;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  position;
    logic [31:0] element;
    bit          hold_for_drain;  // wait for every outstanding result first
  } list_request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] element;
    logic [6:0]  count;
    logic        is_empty;
  } list_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  positional_list_insert_remove_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // cmd, position, element, zero pad
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // status, element_out, count, is_empty, zero pad
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Shadow list and outcome prediction
  // -------------------------------------------------------------------------
  logic [31:0] shadow_list [CAPACITY];
  int          shadow_len = 0;

  int n_insert = 0, n_remove = 0, n_read = 0, n_unused = 0;
  int n_full = 0, n_empty = 0, n_range = 0;

  // Apply one accepted request to the shadow list and return its result word.
  function automatic list_outcome_t apply_list_request(logic [1:0] cmd,
                                                       logic [7:0] pos,
                                                       logic [31:0] elem);
    list_outcome_t o;
    int at;
    int i;
    o.status  = ST_OK;
    o.element = '0;
    case (cmd)
      CMD_INSERT: begin
        n_insert++;
        if (shadow_len >= CAPACITY) begin
          // full list: refuse and leave everything as it is
          o.status = ST_FULL;
          n_full++;
        end else begin
          at = (int'(pos) >= shadow_len) ? shadow_len : int'(pos);
          for (i = shadow_len; i > at; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[at] = elem & ELEM_MASK;
          shadow_len++;
        end
      end
      CMD_REMOVE: begin
        n_remove++;
        if (shadow_len == 0) begin
          o.status = ST_EMPTY;
          n_empty++;
        end else begin
          // positions at or past the last entry take the last entry
          at = (int'(pos) >= shadow_len - 1) ? shadow_len - 1 : int'(pos);
          o.element = shadow_list[at];
          for (i = at; i < shadow_len - 1; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      CMD_READ: begin
        n_read++;
        if (shadow_len == 0) begin
          o.status = ST_EMPTY;
          n_empty++;
        end else if (int'(pos) >= shadow_len) begin
          o.status = ST_RANGE;
          n_range++;
        end else begin
          o.element = shadow_list[pos];
        end
      end
      default: n_unused++;
    endcase
    o.count    = 7'(shadow_len);
    o.is_empty = (shadow_len == 0);
    return o;
  endfunction

  // -------------------------------------------------------------------------
  // Request backlog, filled once at time zero
  // -------------------------------------------------------------------------
  list_request_t request_backlog[$];
  int            requests_queued = 0;
  int            est_len = 0;  // list length as the generator sees it

  task automatic queue_request(logic [1:0] cmd, logic [7:0] pos, logic [31:0] elem,
                               bit hold = 1'b0);
    list_request_t r;
    r.cmd = cmd;
    r.position = pos;
    r.element = elem;
    r.hold_for_drain = hold;
    request_backlog.push_back(r);
    requests_queued++;
    // track the length so random positions land near the live region
    if (cmd == CMD_INSERT && est_len < CAPACITY) est_len++;
    if (cmd == CMD_REMOVE && est_len > 0) est_len--;
  endtask

  function automatic logic [7:0] pick_position();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 8'($urandom_range(0, est_len));
    if (roll < 75) return 8'($urandom_range(0, 255));
    if (roll < 88) return 8'd255;
    return 8'd0;
  endfunction

  initial begin
    int phase_kind;
    int phase_len;
    int roll;
    int ins_pct;
    int rem_pct;
    int k;
    logic [1:0] cmd;

    // Directed: empty-list cases, appends, middle inserts, reads past the end,
    // removes at the last index and beyond, and the reserved code.
    queue_request(CMD_READ,   8'd0,   32'h0000_0000);
    queue_request(CMD_REMOVE, 8'd0,   32'h0000_0000);
    queue_request(CMD_UNUSED, 8'd0,   32'hFFFF_FFFF);
    queue_request(CMD_INSERT, 8'd255, 32'h0000_0000);
    queue_request(CMD_READ,   8'd1,   32'h0000_0000);
    queue_request(CMD_INSERT, 8'd0,   32'hFFFF_FFFF);
    queue_request(CMD_INSERT, 8'd1,   32'hA5A5_A5A5);
    queue_request(CMD_INSERT, 8'd200, 32'h5A5A_5A5A);
    queue_request(CMD_READ,   8'd0,   32'hFFFF_FFFF);
    queue_request(CMD_READ,   8'd3,   32'h0000_0000);
    queue_request(CMD_READ,   8'd4,   32'h0000_0000);
    queue_request(CMD_READ,   8'd255, 32'h0000_0000);
    queue_request(CMD_UNUSED, 8'd255, 32'h1234_5678);
    queue_request(CMD_REMOVE, 8'd1,   32'hFFFF_FFFF);
    queue_request(CMD_REMOVE, 8'd255, 32'h0000_0000);
    queue_request(CMD_REMOVE, 8'd1,   32'h0000_0000);
    queue_request(CMD_REMOVE, 8'd0,   32'h0000_0000);
    queue_request(CMD_REMOVE, 8'd255, 32'h0000_0000);
    queue_request(CMD_READ,   8'd255, 32'h0000_0000);

    // Fill to capacity at random places, then knock on the full list twice.
    for (k = 0; k < CAPACITY + 2; k++)
      queue_request(CMD_INSERT, pick_position(), $urandom(), k == 0);
    queue_request(CMD_READ, 8'(CAPACITY - 1), 32'h0);
    queue_request(CMD_READ, 8'(CAPACITY), 32'h0);

    // Random phases: growing, shrinking and mixed traffic, so the list swings
    // between empty and full many times.
    while (requests_queued < RANDOM_WORDS + 25) begin
      phase_kind = $urandom_range(0, 2);
      phase_len  = $urandom_range(20, 120);
      case (phase_kind)
        0:       begin ins_pct = 75; rem_pct = 10; end
        1:       begin ins_pct = 15; rem_pct = 70; end
        default: begin ins_pct = 35; rem_pct = 30; end
      endcase
      for (k = 0; k < phase_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)                cmd = CMD_INSERT;
        else if (roll < ins_pct + rem_pct) cmd = CMD_REMOVE;
        else if (roll < 97)                cmd = CMD_READ;
        else                               cmd = CMD_UNUSED;
        queue_request(cmd, pick_position(), $urandom(),
                      k == 0 && $urandom_range(0, 3) == 0);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Reset: held from time zero, then released on a falling edge
  // -------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // -------------------------------------------------------------------------
  // Driver: change inputs on the falling edge
  // -------------------------------------------------------------------------
  list_outcome_t awaited_results[$];
  logic          req_taken = 1'b0;  // request word moved at the last rising edge
  int            cycle_no = 0;
  int            drain_pauses = 0;

  always @(negedge clk) begin
    bit calm;
    bit idle_now;
    list_request_t r;
    calm     = (cycle_no >= CALM_FROM && cycle_no < CALM_TO);
    idle_now = !calm && ($urandom_range(0, 99) < IDLE_PCT);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      // free to offer a new word; otherwise hold the current one
      if (request_backlog.size() != 0 && !idle_now &&
          !(request_backlog[0].hold_for_drain && awaited_results.size() != 0)) begin
        r = request_backlog.pop_front();
        if (r.hold_for_drain) drain_pauses++;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - 42){1'b0}}, r.element, r.position, r.cmd};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // -------------------------------------------------------------------------
  // Monitor: sample on the rising edge, predict and check
  // -------------------------------------------------------------------------
  int mismatch_count = 0;
  int words_taken = 0;
  int stall_cycles = 0;

  task automatic check_field(string what, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    list_outcome_t want;
    list_outcome_t got;
    if (rst) begin
      req_taken    <= 1'b0;
      stall_cycles <= 0;
    end else begin
      cycle_no  <= cycle_no + 1;
      req_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got.status   = m_tdata[OUT_ST_LSB +: 2];
        got.element  = m_tdata[OUT_ELEM_LSB +: 32];
        got.count    = m_tdata[OUT_CNT_LSB +: 7];
        got.is_empty = m_tdata[OUT_EMP_BIT];
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result word with nothing expected, got status %0d element 0x%0h",
                   $time, got.status, got.element);
        end else begin
          want = awaited_results.pop_front();
          check_field("status",   want.status,   got.status);
          check_field("element",  want.element,  got.element);
          check_field("count",    want.count,    got.count);
          check_field("is_empty", want.is_empty, got.is_empty);
        end
      end
      // predict after checking: a fresh request cannot answer in the same edge
      if (s_tvalid && s_tready) begin
        awaited_results.push_back(apply_list_request(s_tdata[IN_CMD_LSB +: 2],
                                                     s_tdata[IN_POS_LSB +: 8],
                                                     s_tdata[IN_ELEM_LSB +: 32]));
        words_taken <= words_taken + 1;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
      else                                                  stall_cycles <= stall_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: abandon the run if nothing moves for too long
  // -------------------------------------------------------------------------
  initial begin
    while (stall_cycles < STALL_LIMIT) @(negedge clk);
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // -------------------------------------------------------------------------
  // End of run: every request taken, every result back, then a short tail
  // -------------------------------------------------------------------------
  initial begin
    @(negedge clk);
    while (words_taken < requests_queued || awaited_results.size() != 0) @(negedge clk);
    // keep clocking for a short tail to catch stray result words
    repeat (5) @(negedge clk);
    $display("Covered %0d requests: %0d inserts, %0d removes, %0d reads, %0d reserved codes.",
             words_taken, n_insert, n_remove, n_read, n_unused);
    $display("Saw %0d full refusals, %0d empty-list results, %0d reads past the end, %0d drains.",
             n_full, n_empty, n_range, drain_pauses);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/plist_pkg.sv
rtl/plist_cell.sv
rtl/positional_list_insert_remove_unit.sv
test/positional_list_insert_remove_unit_tb.sv
